// ===== rtl/core/fisf_pkg.sv =====
// Package for the reciprocal square root block: stage record type, constants
// and the binary32 multiply / subtract helpers split into front and back halves.
// No dependencies.
`default_nettype none
package fisf_pkg;

	localparam logic [31:0] MAGIC_SEED = 32'h5f3759df;
	localparam logic [31:0] FP_HALF    = 32'h3F000000;
	localparam logic [31:0] FP_ONE_P5  = 32'h3FC00000;
	localparam logic [31:0] CANON_NAN  = 32'h7FC00000;

	// unrounded result: value = mant * 2^(exp - 127 - 46)
	typedef struct packed {
		logic               nan;
		logic               inf;
		logic               zero;
		logic               sign;
		logic signed [10:0] exp;
		logic [47:0]        mant;
	} fpre_t;

	function automatic logic is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
	endfunction

	function automatic logic [23:0] sig24(input logic [31:0] a);
		return {(a[30:23] != 8'd0), a[22:0]};
	endfunction

	function automatic logic [7:0] eff_exp(input logic [31:0] a);
		return (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
	endfunction

	function automatic fpre_t fmul_pre(input logic [31:0] a, input logic [31:0] b);
		fpre_t r;
		r.sign = a[31] ^ b[31];
		r.nan  = is_nan(a) || is_nan(b) ||
			(is_inf(a) && (a[30:0] == 31'd0 || b[30:0] == 31'd0)) ||
			(is_inf(b) && (a[30:0] == 31'd0 || b[30:0] == 31'd0));
		r.inf  = is_inf(a) || is_inf(b);
		r.exp  = $signed({3'b000, eff_exp(a)}) + $signed({3'b000, eff_exp(b)}) - 11'sd127;
		r.mant = sig24(a) * sig24(b);
		r.zero = (r.mant == 48'd0);
		return r;
	endfunction

	// a - b
	function automatic fpre_t fsub_pre(input logic [31:0] a, input logic [31:0] b);
		fpre_t       r;
		logic        sb;
		logic        a_big;
		logic [31:0] lg;
		logic [31:0] sm;
		logic        s_lg;
		logic        s_sm;
		logic [7:0]  d;
		logic [4:0]  sh;
		logic [53:0] ext;
		logic [26:0] al;
		logic [27:0] sum;
		sb    = ~b[31];
		a_big = (a[30:0] >= b[30:0]);
		lg    = a_big ? a : b;
		sm    = a_big ? b : a;
		s_lg  = a_big ? a[31] : sb;
		s_sm  = a_big ? sb : a[31];
		d     = eff_exp(lg) - eff_exp(sm);
		sh    = (d > 8'd27) ? 5'd27 : d[4:0];
		ext   = {sig24(sm), 30'd0} >> sh;
		al    = {ext[53:28], ext[27] | (ext[26:0] != 27'd0)};
		if (s_lg == s_sm)
			sum = {1'b0, sig24(lg), 3'b000} + {1'b0, al};
		else
			sum = {1'b0, sig24(lg), 3'b000} - {1'b0, al};
		r.nan  = is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != sb));
		r.inf  = is_inf(a) || is_inf(b);
		r.exp  = $signed({3'b000, eff_exp(lg)});
		r.mant = {sum, 20'd0};
		r.zero = (sum == 28'd0);
		// exact cancellation gives +0 unless both terms are -0
		r.sign = r.zero ? (a[31] & sb) : (r.inf ? (is_inf(a) ? a[31] : sb) : s_lg);
		return r;
	endfunction

	function automatic logic [31:0] fround(input fpre_t p);
		logic [5:0]         lz;
		logic [47:0]        n;
		logic signed [10:0] er;
		logic [4:0]         sh;
		logic [71:0]        ext;
		logic [23:0]        keep;
		logic               g;
		logic               s;
		logic [30:0]        mag;
		int                 i;
		lz = 6'd0;
		for (i = 0; i < 48; i++) begin
			if (p.mant[i])
				lz = 6'(47 - i);
		end
		n  = p.mant << lz;
		er = p.exp + 11'sd1 - $signed({5'b00000, lz});
		if (er >= 11'sd1) begin
			keep = n[47:24];
			g    = n[23];
			s    = (n[22:0] != 23'd0);
			mag  = {er[7:0], keep[22:0]};
		end else begin
			sh   = (er < -11'sd23) ? 5'd25 : 5'(11'sd1 - er);
			ext  = {n, 24'd0} >> sh;
			keep = ext[71:48];
			g    = ext[47];
			s    = (ext[46:0] != 47'd0);
			mag  = {8'd0, keep[22:0]};
		end
		if (p.nan)
			return CANON_NAN;
		if (p.inf || er >= 11'sd255)
			return {p.sign, 8'hFF, 23'd0};
		if (p.zero)
			return {p.sign, 31'd0};
		mag = mag + {30'd0, g & (s | keep[0])};
		return {p.sign, mag};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fast_inverse_sqrt_float.sv =====
// Approximate 1/sqrt(x) on binary32: magic-constant seed plus one Newton step.
// Result word is registered in res_s10; one word per cycle while the output is not stalled.
// Four multiplies and one subtract, each a front stage and a round stage.
// The whole pipe holds while the output word is stalled.
// Reset clears the valid bits only; the pipe is empty after reset.
`default_nettype none
module fast_inverse_sqrt_float
	import fisf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        operand_valid,
	output logic             operand_stall,
	input  wire logic [31:0] operand_bits,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [31:0]      recip_root_bits
);

	logic        en;
	logic [10:1] vld;
	fpre_t       pre_s1, pre_s3, pre_s5, pre_s7, pre_s9;
	logic [31:0] half_s2, p_s4, q_s6, corr_s8, res_s10;
	logic [31:0] seed_s1, seed_s2, seed_s3, seed_s4, seed_s5, seed_s6, seed_s7, seed_s8;
	logic [31:0] seed_in;

	assign en            = !(vld[10] && result_stall);
	assign operand_stall = !en;
	assign seed_in       = MAGIC_SEED - {operand_bits[31], operand_bits[31:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (en) begin
			vld <= {vld[9:1], operand_valid};
		end
	end

	// advance all stages together; hold on output stall
	always_ff @(posedge clk) begin
		if (en) begin
			pre_s1  <= fmul_pre(operand_bits, FP_HALF);
			seed_s1 <= seed_in;
			half_s2 <= fround(pre_s1);
			seed_s2 <= seed_s1;
			pre_s3  <= fmul_pre(half_s2, seed_s2);
			seed_s3 <= seed_s2;
			p_s4    <= fround(pre_s3);
			seed_s4 <= seed_s3;
			pre_s5  <= fmul_pre(p_s4, seed_s4);
			seed_s5 <= seed_s4;
			q_s6    <= fround(pre_s5);
			seed_s6 <= seed_s5;
			pre_s7  <= fsub_pre(FP_ONE_P5, q_s6);
			seed_s7 <= seed_s6;
			corr_s8 <= fround(pre_s7);
			seed_s8 <= seed_s7;
			pre_s9  <= fmul_pre(seed_s8, corr_s8);
			res_s10 <= fround(pre_s9);
		end
	end

	assign result_valid    = vld[10];
	assign recip_root_bits = res_s10;

endmodule
`default_nettype wire

// ===== rtl/core/fisf_checker.sv =====
// Port-level checker for the reciprocal square root block, with its bind.
// Depends on fast_inverse_sqrt_float only through the bind.
`default_nettype none
module fisf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        operand_valid,
	input wire logic        operand_stall,
	input wire logic [31:0] operand_bits,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [31:0] recip_root_bits
);

	// a stalled result word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(recip_root_bits))
		else $error("result word changed under stall");

	// input side stalls only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		operand_stall |-> result_valid && result_stall)
		else $error("operand stalled without output back-pressure");

	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!result_stall |-> !operand_stall)
		else $error("operand stalled while output drains");

	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && recip_root_bits[30:23] == 8'hFF && recip_root_bits[22:0] != 23'd0
		|-> recip_root_bits == 32'h7FC00000)
		else $error("non-canonical NaN on result");

endmodule

bind fast_inverse_sqrt_float fisf_checker u_fisf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.operand_valid   (operand_valid),
	.operand_stall   (operand_stall),
	.operand_bits    (operand_bits),
	.result_valid    (result_valid),
	.result_stall    (result_stall),
	.recip_root_bits (recip_root_bits)
);
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for fast_inverse_sqrt_float: directed table, then random words under
// three sender/receiver idle mixes, checked against a bit-exact binary32 predictor or typed words.
// Depends on fisf_pkg for the seed and NaN constants.
`default_nettype none
module tb_top
	import fisf_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        operand_valid;
	logic        operand_stall;
	logic [31:0] operand_bits;
	logic        result_valid;
	logic        result_stall;
	logic [31:0] recip_root_bits;

	fast_inverse_sqrt_float uut (
		.clk(clk), .arst_n(arst_n),
		.operand_valid(operand_valid), .operand_stall(operand_stall),
		.operand_bits(operand_bits),
		.result_valid(result_valid), .result_stall(result_stall),
		.recip_root_bits(recip_root_bits)
	);

	localparam logic [31:0] F_HALF   = 32'h3F000000;
	localparam logic [31:0] F_ONE_P5 = 32'h3FC00000;
	localparam logic [31:0] NEG_INF  = 32'hFF800000;

	typedef struct {
		logic [31:0] operand;
		logic        typed;
		logic [31:0] want;
	} vec_t;

	logic [31:0] pending_roots[$];
	int          fail_cnt = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ---- binary32 predictor, round to nearest even ----
	function automatic logic f_is_nan(input logic [31:0] a);
		return a[30:23] == 8'hFF && a[22:0] != 23'd0;
	endfunction

	function automatic logic f_is_inf(input logic [31:0] a);
		return a[30:23] == 8'hFF && a[22:0] == 23'd0;
	endfunction

	// value = m * 2^e
	function automatic void f_split(input logic [31:0] a, output int e, output logic [63:0] m);
		if (a[30:23] == 8'd0) begin
			m = {41'd0, a[22:0]};
			e = -149;
		end else begin
			m = {40'd0, 1'b1, a[22:0]};
			e = int'(a[30:23]) - 150;
		end
	endfunction

	function automatic logic [31:0] f_pack(input logic sgn, input int e, input logic [63:0] m);
		int           p;
		int           ex;
		int           qe;
		int           s;
		logic [127:0] w;
		logic [63:0]  q;
		logic [63:0]  bits;
		logic         g;
		logic         st;
		if (m == 64'd0)
			return {sgn, 31'd0};
		p = 63;
		while (!m[p])
			p--;
		ex = p + e;
		qe = (ex < -126) ? -149 : ex - 23;
		s  = qe - e;
		g  = 1'b0;
		st = 1'b0;
		if (s <= 0)
			q = m << (-s);
		else if (s >= 66) begin
			q  = 64'd0;
			st = 1'b1;
		end else begin
			w  = {m, 64'd0} >> s;
			q  = w[127:64];
			g  = w[63];
			st = |w[62:0];
		end
		if (g && (st || q[0]))
			q++;
		if (ex < -126)
			bits = q;
		else
			bits = (64'(ex + 127) << 23) + q - 64'h800000;
		if (bits >= 64'h7F800000)
			return {sgn, 8'hFF, 23'd0};
		return {sgn, bits[30:0]};
	endfunction

	function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
		int          ea;
		int          eb;
		logic [63:0] ma;
		logic [63:0] mb;
		logic        sgn;
		sgn = a[31] ^ b[31];
		if (f_is_nan(a) || f_is_nan(b) ||
		    ((f_is_inf(a) || f_is_inf(b)) && (a[30:0] == 31'd0 || b[30:0] == 31'd0)))
			return CANON_NAN;
		if (f_is_inf(a) || f_is_inf(b))
			return {sgn, 8'hFF, 23'd0};
		f_split(a, ea, ma);
		f_split(b, eb, mb);
		return f_pack(sgn, ea + eb, ma * mb);
	endfunction

	function automatic logic [31:0] f_sub(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] nb;
		int          ea;
		int          eb;
		int          eh;
		int          el;
		int          ez;
		int          d;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] mh;
		logic [63:0] ml;
		logic        sh;
		logic        sl;
		nb = {~b[31], b[30:0]};
		if (f_is_nan(a) || f_is_nan(nb) || (f_is_inf(a) && f_is_inf(nb) && a[31] != nb[31]))
			return CANON_NAN;
		if (f_is_inf(a))
			return a;
		if (f_is_inf(nb))
			return nb;
		f_split(a, ea, ma);
		f_split(nb, eb, mb);
		if (ma == 64'd0 && mb == 64'd0)
			return {a[31] & nb[31], 31'd0};
		if (ea >= eb) begin
			eh = ea; mh = ma; sh = a[31]; el = eb; ml = mb; sl = nb[31];
		end else begin
			eh = eb; mh = mb; sh = nb[31]; el = ea; ml = ma; sl = a[31];
		end
		d = eh - el;
		if (d > 38) begin
			// far smaller term only nudges the sticky position
			mh = mh << 30;
			ml = (ml != 64'd0) ? 64'd1 : 64'd0;
			ez = eh - 30;
		end else begin
			mh = mh << d;
			ez = el;
		end
		if (sh == sl)
			return f_pack(sh, ez, mh + ml);
		if (mh == ml)
			return 32'h00000000;
		if (mh > ml)
			return f_pack(sh, ez, mh - ml);
		return f_pack(sl, ez, ml - mh);
	endfunction

	function automatic logic [31:0] recip_root_of(input logic [31:0] x);
		logic [31:0] half;
		logic [31:0] y0;
		logic [31:0] r;
		half = f_mul(F_HALF, x);
		y0   = MAGIC_SEED - {x[31], x[31:1]};
		r    = f_mul(y0, f_sub(F_ONE_P5, f_mul(f_mul(half, y0), y0)));
		return f_is_nan(r) ? CANON_NAN : r;
	endfunction

	// ---- result checking ----
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
		if (arst_n && result_valid && !result_stall) begin
			if (pending_roots.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual %h", $time,
					recip_root_bits);
				fail_cnt++;
			end else begin
				if (recip_root_bits !== pending_roots[0]) begin
					$display("%0t: recip_root_bits mismatch: expected %h, actual %h",
						$time, pending_roots[0], recip_root_bits);
					fail_cnt++;
				end
				void'(pending_roots.pop_front());
			end
		end
	end

	task automatic send_word(input logic [31:0] x, input logic typed, input logic [31:0] want);
		if (send_idle_pct > 0) begin
			while ($urandom_range(99) < send_idle_pct) begin
				operand_valid <= 1'b0;
				@(posedge clk);
			end
		end
		operand_valid <= 1'b1;
		operand_bits  <= x;
		do
			@(posedge clk);
		while (operand_stall);
		pending_roots.push_back(typed ? want : recip_root_of(x));
	endtask

	function automatic logic [31:0] rand_operand();
		logic [31:0] x;
		int          pick;
		x    = $urandom;
		pick = $urandom_range(9);
		case (pick)
			0, 1, 2, 3: x[30:23] = 8'($urandom_range(90, 165));
			4:          x[30:23] = 8'd0;
			5:          x[30:23] = 8'hFF;
			6:          x[30:23] = 8'($urandom_range(1, 3));
			7:          x[30:23] = 8'($urandom_range(250, 254));
			default:    ;
		endcase
		if (pick < 4 && $urandom_range(3) != 0)
			x[31] = 1'b0;
		return x;
	endfunction

	task automatic drain();
		operand_valid <= 1'b0;
		while (pending_roots.size() != 0)
			@(posedge clk);
	endtask

	vec_t directed[] = '{
		'{32'h00000000, 1'b0, 32'h0}, '{32'h80000000, 1'b0, 32'h0},
		'{32'h3F800000, 1'b0, 32'h0}, '{32'h40800000, 1'b0, 32'h0},
		'{32'h3E800000, 1'b0, 32'h0}, '{32'h7F7FFFFF, 1'b0, 32'h0},
		'{32'h00000001, 1'b0, 32'h0}, '{32'h007FFFFF, 1'b0, 32'h0},
		'{32'h00800000, 1'b0, 32'h0}, '{32'h00400000, 1'b0, 32'h0},
		'{32'hBF800000, 1'b0, 32'h0}, '{32'hFF7FFFFF, 1'b0, 32'h0},
		'{32'h80000001, 1'b0, 32'h0}, '{32'h7F800000, 1'b1, NEG_INF},
		'{32'hFF800000, 1'b0, 32'h0}, '{32'h7FC00000, 1'b1, CANON_NAN},
		'{32'h7F800001, 1'b1, CANON_NAN}, '{32'hFFFFFFFF, 1'b1, CANON_NAN},
		'{32'hFFC00000, 1'b1, CANON_NAN}, '{32'h55555555, 1'b0, 32'h0},
		'{32'h2AAAAAAA, 1'b0, 32'h0}, '{32'h5F3759DF, 1'b0, 32'h0}
	};

	initial begin
		operand_valid = 1'b0;
		operand_bits  = 32'd0;
		result_stall  = 1'b0;
		arst_n        = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_word(directed[i].operand, directed[i].typed, directed[i].want);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct  = (ph == 0) ? 24 : (ph == 1) ? 75 : 0;
			recv_stall_pct = (ph == 0) ? 75 : (ph == 1) ? 24 : 0;
			for (int n = 0; n < 343; n++)
				send_word(rand_operand(), 1'b0, 32'h0);
			// hold until the pipe has emptied
			drain();
		end

		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("fast_inverse_sqrt_float regression: pass");
		else
			$display("fast_inverse_sqrt_float regression: fail");
		$finish;
	end

	initial begin
		#2ms;
		$display("fast_inverse_sqrt_float regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
